### src/pmfc_pkg.sv
package pmfc_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned HalfW = 32;
	localparam int unsigned PosW  = 8;
	localparam int unsigned MaxWordsDefault = 256;

	localparam logic [HalfW-1:0] CkPrime = 32'hFFFF_FFFB;

	// one word as it leaves the input register, halves already below the prime
	typedef struct packed {
		logic [HalfW-1:0] lo;
		logic [HalfW-1:0] hi;
		logic             last;
	} item_t;

	// a half is below 2*prime, so one subtract brings it under the prime
	function automatic logic [HalfW-1:0] reduce_half(input logic [HalfW-1:0] h);
		return (h >= CkPrime) ? h - CkPrime : h;
	endfunction

	// both operands below the prime
	function automatic logic [HalfW-1:0] mod_add(input logic [HalfW-1:0] a,
			input logic [HalfW-1:0] b);
		logic [HalfW:0] t;
		t = {1'b0, a} + {1'b0, b};
		if (t >= {1'b0, CkPrime}) begin
			t = t - {1'b0, CkPrime};
		end
		return t[HalfW-1:0];
	endfunction

endpackage

### src/prime_modulus_fletcher_checksum.sv
// Path: a word marked last is captured in the input register and then in the
//   result register, whose contents m_axis shows as the checksum.
// Throughput: one word per cycle; the sum chain of one word is combinational
//   against the running sums. A last word stalls only while the
//   previous checksum still waits in the result register.
// Reset: arst_n clears both sums, the word position and skip_index.
module prime_modulus_fletcher_checksum
	import pmfc_pkg::*;
#(
	parameter int unsigned MaxWords = MaxWordsDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [PosW-1:0]  cfg_data,       // skip_index[7:0]
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [WordW-1:0] s_axis_tdata,   // data_word[63:0]
	input  logic             s_axis_tlast,   // last_word
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [WordW-1:0] m_axis_tdata    // checksum[63:0]
);

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	assign cfg_ready = 1'b1;

	pmfc_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.take          (take),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1)
	);

	pmfc_core #(
		.MaxWords (MaxWords)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1),
		.take          (take),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

### src/pmfc_in_stage.sv
module pmfc_in_stage
	import pmfc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [WordW-1:0] s_axis_tdata,  // data_word[63:0]
	input  logic             s_axis_tlast,  // last_word
	input  logic             take,
	output logic             valid_s1,
	output item_t            item_s1
);

	logic accept;

	assign s_axis_tready = !valid_s1 || take;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// reduce the halves on the way in to shorten the sum chain
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.lo   <= reduce_half(s_axis_tdata[HalfW-1:0]);
			item_s1.hi   <= reduce_half(s_axis_tdata[WordW-1:HalfW]);
			item_s1.last <= s_axis_tlast;
		end
	end

endmodule

### src/pmfc_core.sv
module pmfc_core
	import pmfc_pkg::*;
#(
	parameter int unsigned MaxWords = MaxWordsDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [PosW-1:0]  cfg_data,
	input  logic             valid_s1,
	input  item_t            item_s1,
	output logic             take,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [WordW-1:0] m_axis_tdata
);

	localparam int unsigned LimitInt = (MaxWords - 1 < 255) ? MaxWords - 1 : 255;
	localparam logic [PosW-1:0] PosLimit = PosW'(LimitInt);

	logic [HalfW-1:0] sum_one_q, sum_two_q;
	logic [PosW-1:0]  pos_q, skip_index_q;
	logic             skip;
	logic [HalfW-1:0] one_a, two_a, one_b, two_b;
	logic             out_free;

	assign out_free = !m_axis_tvalid || m_axis_tready;
	// a last word waits in the input register until the result slot frees up
	assign take     = valid_s1 && (!item_s1.last || out_free);

	always_comb begin
		skip  = (pos_q == skip_index_q);
		one_a = skip ? sum_one_q : mod_add(sum_one_q, item_s1.lo);
		two_a = mod_add(sum_two_q, one_a);
		one_b = skip ? one_a : mod_add(one_a, item_s1.hi);
		two_b = mod_add(two_a, one_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_index_q  <= '0;
			sum_one_q     <= '0;
			sum_two_q     <= '0;
			pos_q         <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				skip_index_q <= cfg_data;
			end
			if (take) begin
				if (item_s1.last) begin
					sum_one_q     <= '0;
					sum_two_q     <= '0;
					pos_q         <= '0;
					m_axis_tvalid <= 1'b1;
				end else begin
					sum_one_q <= one_b;
					sum_two_q <= two_b;
					// hold the position once it saturates
					if (pos_q < PosLimit) begin
						pos_q <= pos_q + PosW'(1);
					end
					if (m_axis_tready) begin
						m_axis_tvalid <= 1'b0;
					end
				end
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.last) begin
			m_axis_tdata <= {two_b, one_b};
		end
	end

endmodule

### tb/tb_prime_modulus_fletcher_checksum.sv
module tb_prime_modulus_fletcher_checksum;
	import pmfc_pkg::*;

	localparam int unsigned StallLimit = 3000;
	localparam int unsigned HoldCycles = 200;

	// Expected checksums and the running sums that produce them.
	class checksum_scoreboard;
		localparam logic [31:0] ModPrime = 32'hFFFF_FFFB;
		localparam logic [7:0]  PosLimit = 8'd255;

		logic [31:0]    sum_a;
		logic [31:0]    sum_b;
		logic [7:0]     word_pos;
		logic [7:0]     skip_pos;
		logic [63:0]    checksum_q[$];
		int unsigned    failures;
		int unsigned    words_seen;
		int unsigned    records_seen;
		int unsigned    results_seen;
		int unsigned    words_at_limit;

		function new();
			skip_pos = '0;
			failures = 0;
			words_seen = 0;
			records_seen = 0;
			results_seen = 0;
			words_at_limit = 0;
			clear_record();
		endfunction

		function void clear_record();
			sum_a = '0;
			sum_b = '0;
			word_pos = '0;
		endfunction

		function logic [31:0] add_mod(input logic [31:0] acc, input logic [31:0] addend);
			logic [32:0] t;
			t = {1'b0, acc} + {1'b0, addend};
			return 32'(t % {1'b0, ModPrime});
		endfunction

		function void set_skip(input logic [7:0] v);
			skip_pos = v;
		endfunction

		function void note_word(input logic [63:0] w, input logic last);
			logic excluded;
			excluded = (word_pos == skip_pos);
			words_seen++;
			if (word_pos == PosLimit)
				words_at_limit++;
			if (!excluded)
				sum_a = add_mod(sum_a, w[31:0]);
			sum_b = add_mod(sum_b, sum_a);
			if (!excluded)
				sum_a = add_mod(sum_a, w[63:32]);
			sum_b = add_mod(sum_b, sum_a);
			if (word_pos < PosLimit)
				word_pos = word_pos + 8'd1;
			if (last) begin
				checksum_q.push_back({sum_b, sum_a});
				records_seen++;
				clear_record();
			end
		endfunction

		function void report(input string what, input logic [63:0] exp, input logic [63:0] got);
			failures++;
			if (failures <= 10)
				$display("mismatch: %s expected %h got %h", what, exp, got);
		endfunction

		function void check_result(input logic [63:0] got);
			logic [63:0] exp;
			if (checksum_q.size() == 0) begin
				report("checksum with no record pending,", 'x, got);
			end else begin
				exp = checksum_q.pop_front();
				results_seen++;
				if (got[63:32] !== exp[63:32] || got[31:0] !== exp[31:0])
					report("checksum (sum two : sum one)", exp, got);
			end
		endfunction

		function int unsigned pending();
			return checksum_q.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [PosW-1:0]  cfg_data;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	logic [WordW-1:0] s_axis_tdata;
	logic             s_axis_tlast;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	logic [WordW-1:0] m_axis_tdata;

	checksum_scoreboard sb = new();

	bit          quiet = 1'b0;
	bit          hold_request = 1'b0;
	int unsigned stall_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned words_sent = 0;
	int unsigned skip_settings = 0;

	prime_modulus_fletcher_checksum uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// monitors: every transaction is taken at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_skip(cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_word(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
		end
	end

	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready)
				|| (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= StallLimit) begin
				$display("watchdog: no transaction for %0d cycles", StallLimit);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, or one long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HoldCycles - 1;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(0, 10);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic logic [31:0] pick_half();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF - $urandom_range(0, 7);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input logic [WordW-1:0] w, input logic last);
		int unsigned gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 11);
			@(negedge clk) s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
	endtask

	task automatic send_record(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			send_word({pick_half(), pick_half()}, i == len - 1);
	endtask

	// hold the stream until every checksum is back and the pipe is empty
	task automatic drain();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_skip(input logic [PosW-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk) cfg_valid <= 1'b0;
		skip_settings++;
	endtask

	task automatic run_phase(input logic [PosW-1:0] skip, input int unsigned budget,
			input int unsigned long_len, input bit short_only, input bit hold);
		int unsigned start;
		int unsigned len;
		drain();
		write_skip(skip);
		if (hold)
			hold_request = 1'b1;
		start = words_sent;
		if (long_len != 0)
			send_record(long_len);
		while (words_sent - start < budget) begin
			if (short_only)
				len = $urandom_range(1, 2);
			else if ($urandom_range(0, 3) == 0)
				len = $urandom_range(1, 40);
			else
				len = $urandom_range(1, 8);
			send_record(len);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		write_skip(8'd0);
		// one-word record whose only word sits on the excluded position
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		// halves at, around and above the prime
		send_word(64'h0, 1'b0);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		send_word(64'hFFFF_FFFB_FFFF_FFFC, 1'b0);
		send_word(64'h0000_0001_FFFF_FFFA, 1'b0);
		send_word(64'h0, 1'b1);
		drain();
		write_skip(8'd2);
		send_word(64'hFFFF_FFFA_FFFF_FFFB, 1'b0);
		send_word(64'h1234_5678_9ABC_DEF0, 1'b0);
		send_word(64'hDEAD_BEEF_CAFE_F00D, 1'b0);
		send_word(64'hFFFF_FFFF_0000_0000, 1'b0);
		send_word(64'h0000_0000_FFFF_FFFF, 1'b0);
		send_word(64'hAAAA_5555_5555_AAAA, 1'b1);
		send_word(64'hFFFF_FFFB_FFFF_FFFB, 1'b1);
		send_word(64'h8000_0000_0000_0001, 1'b1);

		// long records run the position counter into saturation
		run_phase(8'd255, 160, 270, 1'b0, 1'b0);
		run_phase(8'd0, 150, 0, 1'b0, 1'b0);
		run_phase(8'($urandom_range(0, 3)), 150, 0, 1'b1, 1'b1);
		run_phase(8'($urandom), 150, 260, 1'b0, 1'b0);
		run_phase(8'd1, 150, 0, 1'b0, 1'b0);
		run_phase(8'($urandom), 150, 0, 1'b0, 1'b0);
		quiet = 1'b1;
		run_phase(8'($urandom_range(0, 7)), 150, 0, 1'b0, 1'b0);
		drain();
		repeat (8) @(posedge clk);

		if (sb.pending() != 0)
			sb.report("record left without checksum,", 'x, 'x);
		$display("covered %0d words in %0d records over %0d skip settings; %0d checksums compared",
			sb.words_seen, sb.records_seen, skip_settings, sb.results_seen);
		$display("%0d words fell on the saturated position; %0d failures",
			sb.words_at_limit, sb.failures);
		if (sb.failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
